/* src/obb_pkg.sv */
// Shared constants for the oriented box overlap test.
package obb_pkg;

	// Port widths of the packed box fields
	localparam int CENTER_W = 63;
	localparam int AXIS_W   = 48;
	localparam int HALF_W   = 63;

	// Default number formats
	localparam int COORD_BITS_DEF     = 21;
	localparam int AXIS_FRAC_BITS_DEF = 14;

	// Rotation margin register
	localparam int              MARGIN_W     = 16;
	localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd1;

	// Result axis index
	localparam int         AXIS_IDX_W = 4;
	localparam int         NUM_AXES   = 15;
	localparam logic [AXIS_IDX_W-1:0] NO_SEP = 4'd15;

	// Cycles from an accepted start to the done strobe
	localparam int LATENCY = 6;

endpackage

/* src/obb_overlap_test.sv */
// Pipelined 15-axis separating axis test for two oriented boxes.
//
//  channel  | signals                                  | handshake
//  ---------+------------------------------------------+-------------------------
//  input    | a_*/b_* center, axis_x/y/z, half_sizes   | start & !busy
//  result   | overlap, first_separating_axis           | done, one cycle, no stall
//  config   | cfg_data (rotation margin)               | cfg_valid & cfg_ready
//
// One box pair enters every cycle; busy is always low and cfg_ready always high.
// The result passes through the six pipeline stages:
// subtract, dot products, sums and rotation terms, wide products, radius sums,
// compare and priority encode. Reset clears the valid bits and sets the margin
// to one. The receiver cannot stall, so the pipeline never holds.
module obb_overlap_test #(
	parameter int COORD_BITS     = obb_pkg::COORD_BITS_DEF,
	parameter int AXIS_FRAC_BITS = obb_pkg::AXIS_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [obb_pkg::CENTER_W-1:0]      a_center,
	input  logic [obb_pkg::AXIS_W-1:0]        a_axis_x,
	input  logic [obb_pkg::AXIS_W-1:0]        a_axis_y,
	input  logic [obb_pkg::AXIS_W-1:0]        a_axis_z,
	input  logic [obb_pkg::HALF_W-1:0]        a_half_sizes,
	input  logic [obb_pkg::CENTER_W-1:0]      b_center,
	input  logic [obb_pkg::AXIS_W-1:0]        b_axis_x,
	input  logic [obb_pkg::AXIS_W-1:0]        b_axis_y,
	input  logic [obb_pkg::AXIS_W-1:0]        b_axis_z,
	input  logic [obb_pkg::HALF_W-1:0]        b_half_sizes,
	output logic                              done,
	output logic                              overlap,
	output logic [obb_pkg::AXIS_IDX_W-1:0]    first_separating_axis,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [obb_pkg::MARGIN_W-1:0]      cfg_data
);

	localparam int C    = COORD_BITS;
	localparam int F    = AXIS_FRAC_BITS;
	localparam int AXW  = F + 2;
	localparam int DW   = C + 1;
	localparam int DAW  = DW + AXW;
	localparam int TW   = DAW + 2;
	localparam int PW   = 2 * AXW;
	localparam int RW   = PW + 2;
	localparam int ABSW = 2 * F + 4;
	localparam int ARW  = ((ABSW > obb_pkg::MARGIN_W) ? ABSW : obb_pkg::MARGIN_W) + 1;
	localparam int HW   = C + ARW;
	localparam int SW   = HW + 3;
	localparam int TLW  = TW / 2;
	localparam int THW  = TW - TLW;
	localparam int PLW  = TLW + 1 + RW;
	localparam int PHW  = THW + RW;
	localparam int CW   = TW + RW + 3;

	logic [obb_pkg::MARGIN_W-1:0] margin_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Hold the rotation margin register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= obb_pkg::MARGIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			margin_q <= cfg_data;
		end
	end

	// Valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			done <= v_s5;
		end
	end

	// Stage 1: unpack fields, take center difference
	logic signed [DW-1:0]  d_s1  [3];
	logic        [C-1:0]   ha_s1 [3];
	logic        [C-1:0]   hb_s1 [3];
	logic signed [AXW-1:0] ax_s1 [3][3];
	logic signed [AXW-1:0] bx_s1 [3][3];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			d_s1[k]  <= DW'($signed(b_center[k*C +: C])) - DW'($signed(a_center[k*C +: C]));
			ha_s1[k] <= a_half_sizes[k*C +: C];
			hb_s1[k] <= b_half_sizes[k*C +: C];
			ax_s1[0][k] <= $signed(a_axis_x[k*AXW +: AXW]);
			ax_s1[1][k] <= $signed(a_axis_y[k*AXW +: AXW]);
			ax_s1[2][k] <= $signed(a_axis_z[k*AXW +: AXW]);
			bx_s1[0][k] <= $signed(b_axis_x[k*AXW +: AXW]);
			bx_s1[1][k] <= $signed(b_axis_y[k*AXW +: AXW]);
			bx_s1[2][k] <= $signed(b_axis_z[k*AXW +: AXW]);
		end
	end

	// Stage 2: component products for t and R
	logic signed [DAW-1:0] da_s2 [3][3];
	logic signed [PW-1:0]  ab_s2 [3][3][3];
	logic        [C-1:0]   ha_s2 [3];
	logic        [C-1:0]   hb_s2 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ha_s2[i] <= ha_s1[i];
			hb_s2[i] <= hb_s1[i];
			for (int k = 0; k < 3; k++) begin
				da_s2[i][k] <= d_s1[k] * ax_s1[i][k];
				for (int j = 0; j < 3; j++) begin
					ab_s2[i][j][k] <= ax_s1[i][k] * bx_s1[j][k];
				end
			end
		end
	end

	// Stage 3: sum dot products, form absolute rotation terms with margin
	logic signed [TW-1:0]  t_s3  [3];
	logic signed [RW-1:0]  r_s3  [3][3];
	logic        [ARW-1:0] ar_s3 [3][3];
	logic        [C-1:0]   ha_s3 [3];
	logic        [C-1:0]   hb_s3 [3];
	logic signed [RW-1:0]  r_c   [3][3];
	logic        [ARW-1:0] ar_c  [3][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				r_c[i][j] = RW'(ab_s2[i][j][0]) + RW'(ab_s2[i][j][1]) + RW'(ab_s2[i][j][2]);
				if (r_c[i][j][RW-1]) begin
					ar_c[i][j] = ARW'($unsigned(ABSW'(-r_c[i][j]))) + ARW'(margin_q);
				end else begin
					ar_c[i][j] = ARW'($unsigned(ABSW'(r_c[i][j]))) + ARW'(margin_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			t_s3[i]  <= TW'(da_s2[i][0]) + TW'(da_s2[i][1]) + TW'(da_s2[i][2]);
			ha_s3[i] <= ha_s2[i];
			hb_s3[i] <= hb_s2[i];
			for (int j = 0; j < 3; j++) begin
				r_s3[i][j]  <= r_c[i][j];
				ar_s3[i][j] <= ar_c[i][j];
			end
		end
	end

	// Stage 4: radius products and split center-projection products
	logic        [HW-1:0]  pa_s4  [3][3];
	logic        [HW-1:0]  pb_s4  [3][3];
	logic        [HW-1:0]  ea1_s4 [3][3];
	logic        [HW-1:0]  ea2_s4 [3][3];
	logic        [HW-1:0]  eb1_s4 [3][3];
	logic        [HW-1:0]  eb2_s4 [3][3];
	logic signed [PLW-1:0] plo_s4 [3][3][3];
	logic signed [PHW-1:0] phi_s4 [3][3][3];
	logic signed [TW-1:0]  t_s4   [3];
	logic        [C-1:0]   ha_s4  [3];
	logic        [C-1:0]   hb_s4  [3];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			t_s4[k]  <= t_s3[k];
			ha_s4[k] <= ha_s3[k];
			hb_s4[k] <= hb_s3[k];
			for (int j = 0; j < 3; j++) begin
				pa_s4[k][j] <= ha_s3[k] * ar_s3[k][j];
				pb_s4[k][j] <= hb_s3[j] * ar_s3[k][j];
				// edge axis radius terms, rows and columns taken cyclically
				ea1_s4[k][j] <= ha_s3[(k + 1) % 3] * ar_s3[(k + 2) % 3][j];
				ea2_s4[k][j] <= ha_s3[(k + 2) % 3] * ar_s3[(k + 1) % 3][j];
				eb1_s4[k][j] <= hb_s3[(j + 1) % 3] * ar_s3[k][(j + 2) % 3];
				eb2_s4[k][j] <= hb_s3[(j + 2) % 3] * ar_s3[k][(j + 1) % 3];
				for (int l = 0; l < 3; l++) begin
					plo_s4[k][l][j] <= $signed({1'b0, t_s3[k][TLW-1:0]}) * r_s3[l][j];
					phi_s4[k][l][j] <= $signed(t_s3[k][TW-1:TLW]) * r_s3[l][j];
				end
			end
		end
	end

	// Stage 5: projected radii and center distances per axis
	logic signed [CW-1:0] tr_c  [3][3][3];
	logic signed [CW-1:0] lhs_c [obb_pkg::NUM_AXES];
	logic        [CW-1:0] rhs_c [obb_pkg::NUM_AXES];
	logic        [SW-1:0] sum_c;
	logic signed [CW-1:0] lhs_s5 [obb_pkg::NUM_AXES];
	logic        [CW-1:0] rhs_s5 [obb_pkg::NUM_AXES];

	always_comb begin
		int i1, i2;
		for (int k = 0; k < 3; k++) begin
			for (int l = 0; l < 3; l++) begin
				for (int j = 0; j < 3; j++) begin
					tr_c[k][l][j] = (CW'(phi_s4[k][l][j]) <<< TLW) + CW'(plo_s4[k][l][j]);
				end
			end
		end
		// face axes of A
		for (int i = 0; i < 3; i++) begin
			sum_c = (SW'(ha_s4[i]) << (2 * F)) + SW'(pb_s4[i][0]) + SW'(pb_s4[i][1])
				+ SW'(pb_s4[i][2]);
			lhs_c[i] = CW'(t_s4[i]) <<< F;
			rhs_c[i] = CW'(sum_c);
		end
		// face axes of B
		for (int j = 0; j < 3; j++) begin
			sum_c = SW'(pa_s4[0][j]) + SW'(pa_s4[1][j]) + SW'(pa_s4[2][j])
				+ (SW'(hb_s4[j]) << (2 * F));
			lhs_c[3 + j] = tr_c[0][0][j] + tr_c[1][1][j] + tr_c[2][2][j];
			rhs_c[3 + j] = CW'(sum_c) << F;
		end
		// edge cross products
		for (int i = 0; i < 3; i++) begin
			i1 = (i + 1) % 3;
			i2 = (i + 2) % 3;
			for (int j = 0; j < 3; j++) begin
				sum_c = SW'(ea1_s4[i][j]) + SW'(ea2_s4[i][j]) + SW'(eb1_s4[i][j])
					+ SW'(eb2_s4[i][j]);
				lhs_c[6 + 3 * i + j] = tr_c[i2][i1][j] - tr_c[i1][i2][j];
				rhs_c[6 + 3 * i + j] = CW'(sum_c) << F;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int n = 0; n < obb_pkg::NUM_AXES; n++) begin
			lhs_s5[n] <= lhs_c[n];
			rhs_s5[n] <= rhs_c[n];
		end
	end

	// Stage 6: compare and pick the first separating axis
	logic [obb_pkg::NUM_AXES-1:0]   sep_c;
	logic [obb_pkg::AXIS_IDX_W-1:0] axis_c;
	logic [CW-1:0]                  mag_c;

	always_comb begin
		axis_c = obb_pkg::NO_SEP;
		for (int n = 0; n < obb_pkg::NUM_AXES; n++) begin
			mag_c    = lhs_s5[n][CW-1] ? CW'(-lhs_s5[n]) : CW'(lhs_s5[n]);
			sep_c[n] = mag_c > rhs_s5[n];
		end
		for (int n = obb_pkg::NUM_AXES - 1; n >= 0; n--) begin
			if (sep_c[n]) begin
				axis_c = obb_pkg::AXIS_IDX_W'(n);
			end
		end
	end

	always_ff @(posedge clk) begin
		first_separating_axis <= axis_c;
		overlap               <= (axis_c == obb_pkg::NO_SEP);
	end

endmodule

/* src/obb_checker.sv */
// Port-level checks for the oriented box overlap test, bound to the top level.
module obb_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic                           overlap,
	input logic [obb_pkg::AXIS_IDX_W-1:0] first_separating_axis
);

	// every accepted beat yields a done strobe after the pipeline latency
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(obb_pkg::LATENCY) done)
		else $error("accepted beat produced no result");

	// no result without an accepted beat
	a_done_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, obb_pkg::LATENCY))
		else $error("result without accepted beat");

	// overlap flag agrees with the axis index
	a_overlap_axis: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (overlap == (first_separating_axis == obb_pkg::NO_SEP)))
		else $error("overlap and axis index disagree");

	// a separating axis index is in range
	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !overlap) |-> (first_separating_axis < obb_pkg::AXIS_IDX_W'(obb_pkg::NUM_AXES)))
		else $error("separating axis index out of range");

endmodule

bind obb_overlap_test obb_checker u_obb_checker (
	.clk                   (clk),
	.arst_n                (arst_n),
	.start                 (start),
	.busy                  (busy),
	.done                  (done),
	.overlap               (overlap),
	.first_separating_axis (first_separating_axis)
);
